[rtl/core/spsn_pkg.sv]
// shared codes for the path segment normalizer: command and segment kind encodings
// no dependencies
package spsn_pkg;

  // command codes on the op input
  localparam logic [3:0] OP_MOVE_ABS   = 4'd0;
  localparam logic [3:0] OP_LINE_ABS   = 4'd1;
  localparam logic [3:0] OP_HORIZ_ABS  = 4'd2;
  localparam logic [3:0] OP_VERT_ABS   = 4'd3;
  localparam logic [3:0] OP_CUBIC_ABS  = 4'd4;
  localparam logic [3:0] OP_SMOOTH_ABS = 4'd5;
  localparam logic [3:0] OP_CLOSE      = 4'd6;
  localparam logic [3:0] OP_MOVE_REL   = 4'd7;
  localparam logic [3:0] OP_LINE_REL   = 4'd8;
  localparam logic [3:0] OP_HORIZ_REL  = 4'd9;
  localparam logic [3:0] OP_VERT_REL   = 4'd10;
  localparam logic [3:0] OP_CUBIC_REL  = 4'd11;
  localparam logic [3:0] OP_SMOOTH_REL = 4'd12;

  typedef enum logic [2:0] {
    KIND_MOVE    = 3'd0,
    KIND_LINE    = 3'd1,
    KIND_CUBIC   = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

endpackage

[rtl/core/svg_path_segment_normalizer.sv]
// path command normalizer: turns one path command word into one absolute segment word
// depends on spsn_pkg for command and kind codes
// latency: a result word is valid the cycle after its command word is accepted
// throughput: one command word per cycle; the input is taken while the result register
// is empty or its word is being taken in the same cycle
// all work is one saturating add or reflection per coordinate against the state registers
// reset: synchronous, clears current point, subpath start, last control point and flags
module svg_path_segment_normalizer #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3:0]                   op,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output spsn_pkg::kind_t              kind,
  output logic signed [COORD_BITS-1:0] from_x,
  output logic signed [COORD_BITS-1:0] from_y,
  output logic signed [COORD_BITS-1:0] ctl1_x,
  output logic signed [COORD_BITS-1:0] ctl1_y,
  output logic signed [COORD_BITS-1:0] ctl2_x,
  output logic signed [COORD_BITS-1:0] ctl2_y,
  output logic signed [COORD_BITS-1:0] to_x,
  output logic signed [COORD_BITS-1:0] to_y
);
  import spsn_pkg::*;

  localparam int WideBits = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WideBits-1:0]   wide_t;

  localparam wide_t SatHi = wide_t'({3'b000, {(COORD_BITS - 1){1'b1}}});
  localparam wide_t SatLo = ~SatHi;

  function automatic coord_t sat(input wide_t v);
    coord_t r;
    if (v > SatHi) begin
      r = SatHi[COORD_BITS-1:0];
    end else if (v < SatLo) begin
      r = SatLo[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic wide_t widen(input coord_t v);
    return {{2{v[COORD_BITS-1]}}, v};
  endfunction

  // state
  coord_t cur_x, cur_y;
  coord_t sub_start_x, sub_start_y;
  coord_t last_ctl_x, last_ctl_y;
  logic   prev_was_cubic;
  logic   seen_point;

  // combinational segment
  logic   rel;
  coord_t org_x, org_y;
  coord_t sum_ax, sum_ay, sum_bx, sum_by, sum_cx, sum_cy;
  coord_t refl_x, refl_y;
  kind_t  kind_next;
  coord_t ctl1_x_next, ctl1_y_next, ctl2_x_next, ctl2_y_next, to_x_next, to_y_next;
  logic   accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rel = (op >= OP_MOVE_REL) && (op <= OP_SMOOTH_REL);
    org_x = rel ? cur_x : '0;
    org_y = rel ? cur_y : '0;
    // a relative move before any point is set counts as absolute
    if (op == OP_MOVE_REL && !seen_point) begin
      org_x = '0;
      org_y = '0;
    end
    sum_ax = sat(widen(org_x) + widen(ax));
    sum_ay = sat(widen(org_y) + widen(ay));
    sum_bx = sat(widen(org_x) + widen(bx));
    sum_by = sat(widen(org_y) + widen(by));
    sum_cx = sat(widen(org_x) + widen(cx));
    sum_cy = sat(widen(org_y) + widen(cy));
    // reflection of the last control point about the current point
    refl_x = sat({cur_x[COORD_BITS-1], cur_x, 1'b0} - widen(last_ctl_x));
    refl_y = sat({cur_y[COORD_BITS-1], cur_y, 1'b0} - widen(last_ctl_y));

    kind_next   = KIND_IGNORED;
    ctl1_x_next = '0;
    ctl1_y_next = '0;
    ctl2_x_next = '0;
    ctl2_y_next = '0;
    to_x_next   = '0;
    to_y_next   = '0;
    case (op)
      OP_MOVE_ABS, OP_MOVE_REL: begin
        kind_next = KIND_MOVE;
        to_x_next = sum_ax;
        to_y_next = sum_ay;
      end
      OP_LINE_ABS, OP_LINE_REL: begin
        kind_next = KIND_LINE;
        to_x_next = sum_ax;
        to_y_next = sum_ay;
      end
      OP_HORIZ_ABS, OP_HORIZ_REL: begin
        kind_next = KIND_LINE;
        to_x_next = sum_ax;
        to_y_next = cur_y;
      end
      OP_VERT_ABS, OP_VERT_REL: begin
        kind_next = KIND_LINE;
        to_x_next = cur_x;
        to_y_next = sum_ay;
      end
      OP_CUBIC_ABS, OP_CUBIC_REL: begin
        kind_next   = KIND_CUBIC;
        ctl1_x_next = sum_ax;
        ctl1_y_next = sum_ay;
        ctl2_x_next = sum_bx;
        ctl2_y_next = sum_by;
        to_x_next   = sum_cx;
        to_y_next   = sum_cy;
      end
      OP_SMOOTH_ABS, OP_SMOOTH_REL: begin
        kind_next   = KIND_CUBIC;
        ctl1_x_next = prev_was_cubic ? refl_x : cur_x;
        ctl1_y_next = prev_was_cubic ? refl_y : cur_y;
        ctl2_x_next = sum_ax;
        ctl2_y_next = sum_ay;
        to_x_next   = sum_bx;
        to_y_next   = sum_by;
      end
      OP_CLOSE: begin
        kind_next = KIND_CLOSE;
        to_x_next = sub_start_x;
        to_y_next = sub_start_y;
      end
      default: begin
        kind_next = KIND_IGNORED;
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x          <= '0;
      cur_y          <= '0;
      sub_start_x    <= '0;
      sub_start_y    <= '0;
      last_ctl_x     <= '0;
      last_ctl_y     <= '0;
      prev_was_cubic <= 1'b0;
      seen_point     <= 1'b0;
    end else if (accept && kind_next != KIND_IGNORED) begin
      cur_x <= to_x_next;
      cur_y <= to_y_next;
      if (kind_next == KIND_MOVE) begin
        sub_start_x <= to_x_next;
        sub_start_y <= to_y_next;
      end
      if (kind_next == KIND_CUBIC) begin
        last_ctl_x <= ctl2_x_next;
        last_ctl_y <= ctl2_y_next;
      end
      prev_was_cubic <= (kind_next == KIND_CUBIC);
      if (kind_next != KIND_CLOSE) begin
        seen_point <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= kind_next;
      from_x <= (kind_next == KIND_IGNORED) ? coord_t'(0) : cur_x;
      from_y <= (kind_next == KIND_IGNORED) ? coord_t'(0) : cur_y;
      ctl1_x <= ctl1_x_next;
      ctl1_y <= ctl1_y_next;
      ctl2_x <= ctl2_x_next;
      ctl2_y <= ctl2_y_next;
      to_x   <= to_x_next;
      to_y   <= to_y_next;
    end
  end

  // the current point follows the end of every segment that is not ignored
  a_cur_follows: assert property (@(posedge clk) disable iff (rst)
    accept && kind_next != KIND_IGNORED |=> cur_x == to_x && cur_y == to_y)
    else $error("current point does not match last segment end");

  // a move opens a subpath at its end point
  a_move_start: assert property (@(posedge clk) disable iff (rst)
    accept && kind_next == KIND_MOVE |=> sub_start_x == to_x && sub_start_y == to_y)
    else $error("subpath start not taken from move");

  // ignored words carry no coordinates
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_IGNORED |-> from_x == 0 && from_y == 0 && to_x == 0
      && to_y == 0 && ctl1_x == 0 && ctl2_x == 0)
    else $error("ignored word has nonzero coordinates");

  // an accepted word always shows up at the output next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word lost");

endmodule
